// File: rtl/pce_pkg.sv
package pce_pkg;

  localparam int COLUMN_BITS_DEF = 16;
  localparam int MAX_TAB_DEF     = 32;

  localparam logic [5:0]  TAB_WIDTH_RST = 6'd8;
  localparam logic [15:0] NO_GOAL       = 16'hFFFF;
  localparam logic [15:0] CNT_MAX       = 16'hFFFF;

  localparam logic [7:0] CODE_TAB   = 8'd9;
  localparam logic [7:0] CODE_CTRL  = 8'd26;
  localparam logic [7:0] CODE_SPACE = 8'd32;
  localparam logic [7:0] CODE_TILDE = 8'd126;
  localparam logic [7:0] CODE_OCT3  = 8'd64;

  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0]  char_code;
    logic        first;
    logic [15:0] start_column;
    logic [15:0] goal_column;
  } pce_in_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        last;
    logic        not_scanned;
    logic [15:0] scanned_count;
  } pce_out_t;

endpackage

// File: rtl/pce_rem_unit.sv
module pce_rem_unit #(
  parameter int COLUMN_BITS = pce_pkg::COLUMN_BITS_DEF,
  parameter int TW          = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [COLUMN_BITS-1:0] dividend,
  input  logic [TW-1:0]          divisor,
  output logic                   done,
  output logic [TW-1:0]          rem
);
  import pce_pkg::*;

  localparam int CW = $clog2(COLUMN_BITS + 1);

  logic [COLUMN_BITS-1:0] shf_r;
  logic [TW-1:0]          rem_r;
  logic [TW-1:0]          dvs_r;
  logic [CW-1:0]          cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic [TW:0]            trial;
  logic [TW:0]            diff;

  // one restoring step per cycle, MSB of the dividend first
  assign trial = {rem_r, shf_r[COLUMN_BITS-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(COLUMN_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shf_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      shf_r <= shf_r << 1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_r <= diff[TW-1:0];
      end else begin
        rem_r <= trial[TW-1:0];
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: rtl/pce_glyph.sv
module pce_glyph #(
  parameter int NW = 6
) (
  input  logic [7:0]    char_code,
  input  logic [NW-1:0] idx,
  input  logic [NW-1:0] tab_len,
  output logic [7:0]    glyph,
  output logic [NW-1:0] len
);
  import pce_pkg::*;

  logic       oct3;
  logic [2:0] digit;

  assign oct3 = (char_code >= CODE_OCT3);

  // pick the octal digit for this position, no leading zeros
  always_comb begin
    digit = char_code[2:0];
    if (oct3) begin
      case (idx)
        NW'(1):  digit = {1'b0, char_code[7:6]};
        NW'(2):  digit = char_code[5:3];
        default: digit = char_code[2:0];
      endcase
    end else begin
      case (idx)
        NW'(1):  digit = char_code[5:3];
        default: digit = char_code[2:0];
      endcase
    end
  end

  always_comb begin
    if (char_code == CODE_TAB) begin
      glyph = CH_SPACE;
      len   = tab_len;
    end else if (char_code <= CODE_CTRL) begin
      glyph = (idx == '0) ? CH_CARET : (CH_AT + char_code);
      len   = NW'(2);
    end else if (char_code >= CODE_SPACE && char_code <= CODE_TILDE) begin
      glyph = char_code;
      len   = NW'(1);
    end else begin
      glyph = (idx == '0) ? CH_BSL : (CH_ZERO + {5'd0, digit});
      len   = oct3 ? NW'(4) : NW'(3);
    end
  end

endmodule

// File: rtl/printable_char_expander_unit.sv
// An accepted word passes the DECIDE and EMIT states before its first result is registered;
// a tab also waits in DIV for the bit-serial remainder unit (column mod tab width).
// Throughput: one result word per cycle while out_ready is high; a new input word is
// accepted only after the last result word of the previous one has been emitted.
// Reset (synchronous, rst_n low): column 0, no goal, count 0, tab width 8, channels empty.
module printable_char_expander_unit #(
  parameter int COLUMN_BITS = pce_pkg::COLUMN_BITS_DEF,
  parameter int MAX_TAB     = pce_pkg::MAX_TAB_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pce_pkg::pce_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pce_pkg::pce_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [5:0]        cfg_wr_data
);
  import pce_pkg::*;

  localparam int TW    = $clog2(MAX_TAB + 1);
  localparam int NW    = (TW > 3) ? TW : 3;
  localparam int CMP_W = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;
  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]             state_r;
  logic [5:0]             tab_width_r;
  logic [COLUMN_BITS-1:0] column_r;
  logic [15:0]            goal_r;
  logic [15:0]            scanned_r;
  logic [7:0]             code_r;
  logic                   ns_r;
  logic [NW-1:0]          len_r;
  logic [NW-1:0]          idx_r;
  logic                   out_valid_r;
  pce_out_t               out_data_r;

  logic [TW-1:0]          tab_eff;
  logic [TW-1:0]          rem;
  logic                   rem_done;
  logic                   div_start;
  logic [NW-1:0]          tab_len;
  logic [7:0]             glyph;
  logic [NW-1:0]          glyph_len;
  logic [CMP_W-1:0]       start_ext;
  logic [COLUMN_BITS-1:0] start_sat;
  logic                   goal_hit;
  logic [NW-1:0]          run_len;
  logic [COLUMN_BITS:0]   col_sum;
  logic                   in_acc;
  logic                   slot_free;
  logic                   emit_go;
  logic                   is_last;

  // clamp tab width into 1..MAX_TAB
  always_comb begin
    if (tab_width_r == '0) begin
      tab_eff = TW'(1);
    end else if (int'(tab_width_r) > MAX_TAB) begin
      tab_eff = TW'(MAX_TAB);
    end else begin
      tab_eff = TW'(tab_width_r);
    end
  end

  assign start_ext = CMP_W'(in_data.start_column);
  assign start_sat = (start_ext > CMP_W'(COL_MAX)) ? COL_MAX : start_ext[COLUMN_BITS-1:0];
  assign goal_hit  = (goal_r != NO_GOAL) && (CMP_W'(column_r) >= CMP_W'(goal_r));

  assign tab_len   = NW'(tab_eff) - NW'(rem);
  assign run_len   = (state_r == S_DIV) ? tab_len : glyph_len;
  assign col_sum   = {1'b0, column_r} + (COLUMN_BITS + 1)'(run_len);

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign emit_go   = (state_r == S_EMIT) && slot_free;
  assign is_last   = ns_r || (idx_r == len_r - 1'b1);
  assign div_start = (state_r == S_DECIDE) && !goal_hit && (code_r == CODE_TAB);

  pce_rem_unit #(
    .COLUMN_BITS(COLUMN_BITS),
    .TW         (TW)
  ) u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(column_r),
    .divisor (tab_eff),
    .done    (rem_done),
    .rem     (rem)
  );

  pce_glyph #(
    .NW(NW)
  ) u_glyph (
    .char_code(code_r),
    .idx      (idx_r),
    .tab_len  (len_r),
    .glyph    (glyph),
    .len      (glyph_len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_width_r <= TAB_WIDTH_RST;
    end else if (cfg_wr_en) begin
      tab_width_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      column_r    <= '0;
      goal_r      <= NO_GOAL;
      scanned_r   <= '0;
      out_valid_r <= 1'b0;
      ns_r        <= 1'b0;
      idx_r       <= '0;
      len_r       <= '0;
      code_r      <= '0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            code_r <= in_data.char_code;
            if (in_data.first) begin
              column_r  <= start_sat;
              goal_r    <= in_data.goal_column;
              scanned_r <= '0;
            end
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          idx_r <= '0;
          if (goal_hit) begin
            ns_r    <= 1'b1;
            len_r   <= NW'(1);
            state_r <= S_EMIT;
          end else if (code_r == CODE_TAB) begin
            ns_r    <= 1'b0;
            state_r <= S_DIV;
          end else begin
            ns_r     <= 1'b0;
            len_r    <= glyph_len;
            column_r <= col_sum[COLUMN_BITS] ? COL_MAX : col_sum[COLUMN_BITS-1:0];
            if (scanned_r != CNT_MAX) begin
              scanned_r <= scanned_r + 1'b1;
            end
            state_r <= S_EMIT;
          end
        end
        S_DIV: begin
          if (rem_done) begin
            len_r    <= tab_len;
            column_r <= col_sum[COLUMN_BITS] ? COL_MAX : col_sum[COLUMN_BITS-1:0];
            if (scanned_r != CNT_MAX) begin
              scanned_r <= scanned_r + 1'b1;
            end
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // advance one output word whenever the output register can take it
          if (slot_free) begin
            idx_r <= idx_r + 1'b1;
            if (is_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r.out_char      <= ns_r ? 8'd0 : glyph;
      out_data_r.last          <= is_last;
      out_data_r.not_scanned   <= ns_r;
      out_data_r.scanned_count <= scanned_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input accepted but block still ready");

  a_ns_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.not_scanned) |-> (out_data_r.last && out_data_r.out_char == 8'd0))
    else $error("skipped word must be a single last word with zero char");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (state_r == S_DIV))
    else $error("remainder finished outside tab division");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_valid_r && !out_ready) |=> $stable(idx_r))
    else $error("expansion advanced while output stalled");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pce_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int COL_MAX      = (1 << COLUMN_BITS_DEF) - 1;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  pce_in_t    in_data;
  logic       out_valid;
  logic       out_ready;
  pce_out_t   out_data;
  logic       cfg_wr_en;
  logic [5:0] cfg_wr_data;

  // predicted line state and tab register
  logic [15:0] line_col;
  logic [15:0] line_goal;
  logic [15:0] line_count;
  logic [5:0]  tab_stop;

  pce_out_t pending_glyphs[$];
  pce_out_t head_glyph;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int cycles         = 0;

  int gap_by_phase[4]   = '{0, 63, 0, 27};
  int stall_by_phase[4] = '{0, 0, 63, 27};

  printable_char_expander_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("printable_char_expander_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Expand one accepted byte into the output words it should give.
  function automatic void expand_byte(input pce_in_t w);
    logic [7:0]  glyphs[$];
    pce_out_t    r;
    int          t;
    int unsigned sum;
    if (w.first) begin
      line_col   = w.start_column;
      line_goal  = w.goal_column;
      line_count = '0;
    end
    if (line_goal != NO_GOAL && line_col >= line_goal) begin
      r.out_char      = '0;
      r.last          = 1'b1;
      r.not_scanned   = 1'b1;
      r.scanned_count = line_count;
      pending_glyphs.push_back(r);
      return;
    end
    if (w.char_code == CODE_TAB) begin
      t = (tab_stop == 0) ? 1 : (tab_stop > MAX_TAB_DEF) ? MAX_TAB_DEF : int'(tab_stop);
      repeat (t - int'(line_col) % t) glyphs.push_back(CH_SPACE);
    end else if (w.char_code <= CODE_CTRL) begin
      glyphs.push_back(CH_CARET);
      glyphs.push_back(CH_AT + w.char_code);
    end else if (w.char_code >= CODE_SPACE && w.char_code <= CODE_TILDE) begin
      glyphs.push_back(w.char_code);
    end else begin
      // octal escape, no leading zeros
      glyphs.push_back(CH_BSL);
      if (w.char_code >= CODE_OCT3) glyphs.push_back(CH_ZERO + w.char_code[7:6]);
      glyphs.push_back(CH_ZERO + w.char_code[5:3]);
      glyphs.push_back(CH_ZERO + w.char_code[2:0]);
    end
    if (line_count != CNT_MAX) line_count++;
    sum = int'(line_col) + glyphs.size();
    line_col = (sum > COL_MAX) ? COL_MAX[15:0] : sum[15:0];
    foreach (glyphs[k]) begin
      r.out_char      = glyphs[k];
      r.last          = (k == glyphs.size() - 1);
      r.not_scanned   = 1'b0;
      r.scanned_count = line_count;
      pending_glyphs.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_glyphs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word: char %h last %b ns %b count %0d",
                   out_data.out_char, out_data.last, out_data.not_scanned,
                   out_data.scanned_count);
      end else begin
        head_glyph = pending_glyphs.pop_front();
        if (out_data.out_char !== head_glyph.out_char ||
            out_data.last !== head_glyph.last ||
            out_data.not_scanned !== head_glyph.not_scanned ||
            out_data.scanned_count !== head_glyph.scanned_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word differs: exp %h %b %b %0d, got %h %b %b %0d",
                     head_glyph.out_char, head_glyph.last, head_glyph.not_scanned,
                     head_glyph.scanned_count, out_data.out_char, out_data.last,
                     out_data.not_scanned, out_data.scanned_count);
        end
      end
    end
  end

  task automatic send_word(input pce_in_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    expand_byte(w);
  endtask

  task automatic send_char(input logic [7:0] c, input logic f, input logic [15:0] s,
                           input logic [15:0] g);
    pce_in_t w;
    w.char_code    = c;
    w.first        = f;
    w.start_column = s;
    w.goal_column  = g;
    send_word(w);
  endtask

  // Drop valid and hold until every expected word is back, then let the pipe settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_code();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return CODE_TAB;
    if (r < 45) return 8'($urandom_range(CODE_CTRL));
    if (r < 75) return 8'($urandom_range(CODE_TILDE, CODE_SPACE));
    return 8'($urandom_range(255));
  endfunction

  task automatic test_char_classes();
    logic [7:0] codes[14] = '{8'd26, 8'd27, 8'd31, 8'd32, 8'd126, 8'd127, 8'd128,
                              8'd255, 8'd10, 8'd63, 8'd64, 8'd7, 8'd65, CODE_TAB};
    send_char(8'd0, 1'b1, 16'd3, NO_GOAL);
    foreach (codes[i]) send_char(codes[i], 1'b0, 16'hFFFF, 16'h0000);
    // tab from a tab stop gives a full run of spaces
    send_char(CODE_TAB, 1'b1, 16'd8, NO_GOAL);
  endtask

  task automatic test_goal_stop();
    send_char(8'd65, 1'b1, 16'd5, 16'd5);
    send_char(8'd65, 1'b1, 16'd0, 16'd3);
    send_char(CODE_TAB, 1'b0, 16'd0, 16'd0);
    send_char(8'd66, 1'b0, 16'd0, 16'd0);
    send_char(8'd255, 1'b0, 16'd0, 16'd0);
    send_char(8'd0, 1'b1, 16'd0, 16'd0);
    // no-limit goal at the top column still scans
    send_char(8'd120, 1'b1, 16'hFFFF, NO_GOAL);
    send_char(CODE_TAB, 1'b0, 16'd0, 16'd0);
    send_char(8'd200, 1'b1, 16'd65533, NO_GOAL);
    send_char(CODE_TAB, 1'b0, 16'd0, 16'd0);
    send_char(8'd97, 1'b1, 16'd65533, 16'd65534);
    send_char(8'd98, 1'b0, 16'd0, 16'd0);
  endtask

  task automatic test_tab_stops();
    logic [5:0]  widths[8] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd33, 6'd8, 6'd5, 6'd2};
    logic [15:0] start;
    logic [15:0] goal;
    int          g;
    int          sent;
    int          len;
    widths[7] = 6'($urandom_range(31, 2));
    foreach (widths[i]) begin
      wait_idle();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= widths[i];
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      tab_stop     = widths[i];
      send_gap_pct   = gap_by_phase[i % 4];
      recv_stall_pct = stall_by_phase[i % 4];
      sent = 0;
      while (sent < 40) begin
        if ($urandom_range(9) == 0) begin
          // lone word with any field value
          send_char(8'($urandom_range(255)), 1'($urandom_range(1)),
                    16'($urandom_range(65535)), 16'($urandom_range(65535)));
          sent++;
        end else begin
          case ($urandom_range(4))
            0, 1, 2: start = 16'($urandom_range(40));
            3:       start = 16'($urandom_range(65535));
            default: start = 16'(COL_MAX - $urandom_range(40));
          endcase
          case ($urandom_range(3))
            0, 1: goal = NO_GOAL;
            2: begin
              g    = int'(start) + $urandom_range(60);
              goal = (g > 16'hFFFE) ? 16'hFFFE : g[15:0];
            end
            default: goal = 16'($urandom_range(65535));
          endcase
          len = $urandom_range(20, 1);
          send_char(random_code(), 1'b1, start, goal);
          for (int k = 1; k < len; k++)
            send_char(random_code(), 1'b0, 16'($urandom_range(65535)),
                      16'($urandom_range(65535)));
          sent += len;
        end
      end
    end
  endtask

  // Run one line from just below the column ceiling well past it.
  task automatic test_column_ceiling();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_char(8'd97, 1'b1, 16'(COL_MAX - 20), NO_GOAL);
    repeat (30)
      send_char(random_code(), 1'b0, 16'($urandom_range(65535)),
                16'($urandom_range(65535)));
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    out_ready   <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    line_col   = '0;
    line_goal  = NO_GOAL;
    line_count = '0;
    tab_stop   = TAB_WIDTH_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_char_classes();
    test_goal_stop();
    test_tab_stops();
    test_column_ceiling();

    wait_idle();
    if (mismatches == 0)
      $display("printable_char_expander_unit: match");
    else
      $display("printable_char_expander_unit: mismatch");
    $finish;
  end

endmodule

// File: files.f
rtl/pce_pkg.sv
rtl/pce_rem_unit.sv
rtl/pce_glyph.sv
rtl/printable_char_expander_unit.sv
tb/tb_top.sv
